/* sv/rsip_pkg.sv */
// Package: shared types, codes and character helpers for the radix string parser.
`default_nettype none
package rsip_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned ValueW = 64;

  // Radix limits and the fixed radixes chosen by prefix detection
  localparam logic [CharW-1:0] BASE_MIN = 8'd2;
  localparam logic [CharW-1:0] BASE_MAX = 8'd36;
  localparam logic [BaseW-1:0] BASE_NONE = 6'd0;
  localparam logic [BaseW-1:0] BASE_OCT = 6'd8;
  localparam logic [BaseW-1:0] BASE_DEC = 6'd10;
  localparam logic [BaseW-1:0] BASE_HEX = 6'd16;
  localparam logic [BaseW-1:0] NO_DIGIT = 6'd36;

  // Character codes
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_X_UP  = 8'h58;
  localparam logic [CharW-1:0] CH_X_LO  = 8'h78;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;

  typedef enum logic [8:0] {
    PH_START     = 9'b000000001,
    PH_ZERO      = 9'b000000010,
    PH_SIGN      = 9'b000000100,
    PH_SIGN_ZERO = 9'b000001000,
    PH_WS        = 9'b000010000,
    PH_WANT      = 9'b000100000,
    PH_HEX       = 9'b001000000,
    PH_DIGITS    = 9'b010000000,
    PH_NAN       = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic             dec_ovf;
    logic             oct_ovf;
    logic             main_ovf;
    logic             main_stop;
    logic             dec_stop;
    logic             oct_ok;
  } run_flags_t;

  typedef struct packed {
    logic [CharW-1:0] base_value;
    logic             base_given;
    logic             last_char;
    logic             no_char;
    logic [CharW-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic              overflow;
    logic              is_nan;
    logic [ValueW-1:0] value;
  } result_t;

  function automatic logic [BaseW-1:0] digit_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h5A]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = c - 8'h57;
    end else begin
      v = {2'b00, NO_DIGIT};
    end
    return v[BaseW-1:0];
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

/* sv/rsip_in_stage.sv */
// Input register: holds one accepted item until the parse logic takes it.
`default_nettype none
module rsip_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire rsip_pkg::in_item_t item_i,
  output logic                   valid_o,
  output rsip_pkg::in_item_t     item_o,
  input  wire logic              take_i
);
  import rsip_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // Refill in the same cycle the held item is taken
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

/* sv/rsip_acc.sv */
// Saturating multiply-add of one digit onto an accumulator magnitude.
`default_nettype none
module rsip_acc #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  wire logic [ACC_WIDTH-1:0]        mag_i,
  input  wire logic [rsip_pkg::BaseW-1:0]  base_i,
  input  wire logic [rsip_pkg::BaseW-1:0]  digit_i,
  input  wire logic                        neg_i,
  output logic [ACC_WIDTH-1:0]             sum_o,
  output logic                             ovf_o
);
  import rsip_pkg::*;

  localparam int unsigned ProdW = ACC_WIDTH + BaseW;
  localparam int unsigned TotW  = ProdW + 1;

  logic [ACC_WIDTH-1:0] lim;
  logic [ProdW-1:0]     prod;
  logic [TotW-1:0]      total;

  // Limit is 2^(W-1) for negative numbers, 2^(W-1)-1 otherwise
  assign lim   = neg_i ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
  assign prod  = ProdW'(mag_i) * ProdW'(base_i);
  assign total = TotW'(prod) + TotW'(digit_i);
  assign ovf_o = total > TotW'(lim);
  assign sum_o = ovf_o ? lim : total[ACC_WIDTH-1:0];

endmodule
`default_nettype wire

/* sv/rsip_out_stage.sv */
// Result register: holds one result until the downstream side takes it.
`default_nettype none
module rsip_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  output logic                   free_o,
  input  wire rsip_pkg::result_t res_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rsip_pkg::result_t      res_o
);
  import rsip_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

/* sv/radix_string_integer_parser.sv */
// Top level: streaming radix string-to-integer parser (parseInt style).
//
//  channel  dir  handshake                    payload
//  -------  ---  ---------------------------  -------------------------------------------
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: char_code, base_given, base_value
//                                             tuser: no_char; tlast: last_char
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: value; tuser: is_nan, overflow
//
// Each byte sits in the input register; the parse step (phase update plus three saturating
// multiply-adds of ACC_WIDTH x 6 bits) is combinational, and a result is loaded into the output
// register as the byte leaves the input register. One byte per cycle is sustained while the
// result register has room for each byte that ends a string.
// Reset clears the parse state, the input and the output valid flags.
// A stalled result blocks only a byte that ends a string; other bytes keep flowing.
`default_nettype none
module radix_string_integer_parser #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] char_code, [8] base_given,
                                           // [16:9] base_value, [23:17] zero
  input  wire logic        s_axis_tuser,   // [0] no_char
  input  wire logic        s_axis_tlast,   // last_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] value
  output logic [1:0]       m_axis_tuser    // [0] is_nan, [1] overflow
);
  import rsip_pkg::*;

  // ---------------------------------------------------------------- input register
  in_item_t in_item, item;
  logic     item_vld, fire, ends, out_free;

  assign in_item.char_code  = s_axis_tdata[7:0];
  assign in_item.base_given = s_axis_tdata[8];
  assign in_item.base_value = s_axis_tdata[16:9];
  assign in_item.no_char    = s_axis_tuser;
  assign in_item.last_char  = s_axis_tlast;

  rsip_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (item_vld),
    .item_o  (item),
    .take_i  (fire)
  );

  // A byte that ends a string needs a free result slot; any other byte goes at once
  assign ends = item.no_char || item.last_char;
  assign fire = item_vld && (!ends || out_free);

  // ---------------------------------------------------------------- parse state
  phase_e               phase_q, phase_d;
  logic                 neg_q, neg_d;
  logic [BaseW-1:0]     base_q, base_d;
  logic [ACC_WIDTH-1:0] main_q, main_d;
  logic [ACC_WIDTH-1:0] oct_q, oct_d;
  logic [ACC_WIDTH-1:0] dec_q, dec_d;
  run_flags_t           flags_q, flags_d;

  logic [BaseW-1:0]     digit;
  logic [ACC_WIDTH-1:0] main_sum, oct_sum, dec_sum;
  logic                 main_ovf, oct_ovf, dec_ovf;

  assign digit = digit_value(item.char_code);

  // One multiply-add per accumulator, all from the current state
  rsip_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_main (
    .mag_i (main_q), .base_i (base_q), .digit_i (digit), .neg_i (neg_q),
    .sum_o (main_sum), .ovf_o (main_ovf)
  );
  rsip_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_oct (
    .mag_i (oct_q), .base_i (BASE_OCT), .digit_i (digit), .neg_i (neg_q),
    .sum_o (oct_sum), .ovf_o (oct_ovf)
  );
  rsip_acc #(.ACC_WIDTH(ACC_WIDTH)) u_acc_dec (
    .mag_i (dec_q), .base_i (BASE_DEC), .digit_i (digit), .neg_i (neg_q),
    .sum_o (dec_sum), .ovf_o (dec_ovf)
  );

  // ---------------------------------------------------------------- step logic
  result_t                     res;
  logic                        do_next, want_first, res_nan, res_ovf, res_neg;
  logic [ACC_WIDTH-1:0]        res_mag;
  logic signed [ACC_WIDTH-1:0] res_signed;
  logic [CharW-1:0]            c;

  assign c = item.char_code;

  always_comb begin
    phase_d    = phase_q;
    neg_d      = neg_q;
    base_d     = base_q;
    main_d     = main_q;
    oct_d      = oct_q;
    dec_d      = dec_q;
    flags_d    = flags_q;
    do_next    = 1'b0;
    want_first = 1'b0;
    res_nan    = 1'b0;
    res_ovf    = 1'b0;
    res_neg    = 1'b0;
    res_mag    = '0;

    if (!item.no_char) begin
      case (phase_q)
        PH_START: begin
          if (item.base_given && (item.base_value < BASE_MIN || item.base_value > BASE_MAX)) begin
            phase_d = PH_NAN;
          end else begin
            if (item.base_given) begin
              base_d = item.base_value[BaseW-1:0];
            end
            if (c == CH_ZERO) begin
              phase_d = PH_ZERO;
            end else if (c == CH_MINUS) begin
              neg_d   = 1'b1;
              phase_d = PH_SIGN;
            end else if (c == CH_PLUS) begin
              phase_d = PH_SIGN;
            end else begin
              if (base_d == BASE_NONE) begin
                base_d = BASE_DEC;
              end
              if (is_space(c)) begin
                phase_d = PH_WS;
              end else begin
                want_first = 1'b1;
              end
            end
          end
        end
        PH_ZERO: begin
          if (c == CH_X_UP || c == CH_X_LO) begin
            if (base_q == BASE_NONE) begin
              base_d = BASE_HEX;
            end
            phase_d = PH_HEX;
          end else begin
            // The leading zero counts as the first digit
            phase_d = PH_DIGITS;
            if (base_q == BASE_NONE) begin
              flags_d.oct_ok = 1'b1;
            end
            do_next = 1'b1;
          end
        end
        PH_SIGN: begin
          if (c == CH_ZERO) begin
            phase_d = PH_SIGN_ZERO;
          end else begin
            if (base_q == BASE_NONE) begin
              base_d = BASE_DEC;
            end
            want_first = 1'b1;
          end
        end
        PH_SIGN_ZERO: begin
          if (c == CH_X_UP || c == CH_X_LO) begin
            phase_d = PH_NAN;
          end else begin
            phase_d = PH_DIGITS;
            if (base_q == BASE_NONE) begin
              flags_d.oct_ok = 1'b1;
            end
            do_next = 1'b1;
          end
        end
        PH_WS: begin
          if (is_space(c)) begin
            phase_d = PH_WS;
          end else if (c == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_WANT;
          end else if (c == CH_PLUS) begin
            phase_d = PH_WANT;
          end else begin
            want_first = 1'b1;
          end
        end
        PH_HEX: begin
          if (c == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_WANT;
          end else if (c == CH_PLUS) begin
            phase_d = PH_WANT;
          end else begin
            want_first = 1'b1;
          end
        end
        PH_WANT: begin
          want_first = 1'b1;
        end
        PH_DIGITS: begin
          do_next = 1'b1;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      // First digit: must be valid in the chosen base, else the string is NaN
      if (want_first) begin
        if (digit >= base_d) begin
          phase_d = PH_NAN;
        end else begin
          main_d  = ACC_WIDTH'(digit);
          phase_d = PH_DIGITS;
        end
      end

      // Later digits: octal and decimal run side by side while the base is open, else the main accumulator runs
      if (do_next) begin
        if (base_q == BASE_NONE) begin
          if (flags_d.oct_ok) begin
            if (digit < BASE_OCT) begin
              oct_d           = oct_sum;
              flags_d.oct_ovf = flags_d.oct_ovf | oct_ovf;
            end else begin
              flags_d.oct_ok = 1'b0;
            end
          end
          if (!flags_d.dec_stop) begin
            if (digit < BASE_DEC) begin
              dec_d           = dec_sum;
              flags_d.dec_ovf = flags_d.dec_ovf | dec_ovf;
            end else begin
              flags_d.dec_stop = 1'b1;
            end
          end
        end else if (!flags_d.main_stop) begin
          if (digit < base_q) begin
            main_d           = main_sum;
            flags_d.main_ovf = flags_d.main_ovf | main_ovf;
          end else begin
            flags_d.main_stop = 1'b1;
          end
        end
      end
    end

    // Result from the state after this byte
    if (phase_d == PH_DIGITS) begin
      if (base_d == BASE_NONE) begin
        if (flags_d.oct_ok) begin
          res_mag = oct_d;
          res_ovf = flags_d.oct_ovf;
        end else begin
          res_mag = dec_d;
          res_ovf = flags_d.dec_ovf;
        end
      end else begin
        res_mag = main_d;
        res_ovf = flags_d.main_ovf;
      end
    end else if (phase_d != PH_ZERO && phase_d != PH_SIGN_ZERO) begin
      res_nan = 1'b1;
    end
    // Hold the sign of this string before the state drops back
    res_neg = neg_d;

    // End of string: drop back to the start state
    if (ends) begin
      phase_d = PH_START;
      neg_d   = 1'b0;
      base_d  = BASE_NONE;
      main_d  = '0;
      oct_d   = '0;
      dec_d   = '0;
      flags_d = '0;
    end
  end

  assign res_signed   = res_neg ? signed'(-res_mag) : signed'(res_mag);
  assign res.value    = res_nan ? '0 : ValueW'(res_signed);
  assign res.is_nan   = res_nan;
  assign res.overflow = res_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      base_q  <= BASE_NONE;
      main_q  <= '0;
      oct_q   <= '0;
      dec_q   <= '0;
      flags_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      main_q  <= main_d;
      oct_q   <= oct_d;
      dec_q   <= dec_d;
      flags_q <= flags_d;
    end
  end

  // ---------------------------------------------------------------- result register
  result_t res_out;

  rsip_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && ends),
    .free_o  (out_free),
    .res_i   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = res_out.value;
  assign m_axis_tuser = {res_out.overflow, res_out.is_nan};

endmodule
`default_nettype wire

/* test/radix_string_integer_parser_test.sv */
// Testbench for the streaming radix string parser: directed and random strings against a predictor.
`timescale 1ns / 1ps
module radix_string_integer_parser_test;
  import rsip_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  radix_string_integer_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Parse state of the predictor
  phase_e      ph;
  logic        neg_sign;
  logic [5:0]  radix;
  logic [63:0] acc_main;
  logic [63:0] acc_oct;
  logic [63:0] acc_dec;
  run_flags_t  flags;

  result_t     pending_q[$];
  result_t     got;
  result_t     want;
  int unsigned n_items, n_strings, n_nan, n_sat, n_checked, n_errors;
  logic        idle_on;
  logic        hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous fixed bound on the whole run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_error(string msg);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned char_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return c - CH_ZERO;
    if (c >= CH_A_UP && c < CH_A_UP + 8'd26) return c - CH_A_UP + 10;
    if (c >= CH_A_LO && c < CH_A_LO + 8'd26) return c - CH_A_LO + 10;
    return NO_DIGIT;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic void clear_parse();
    ph       = PH_START;
    neg_sign = 1'b0;
    radix    = BASE_NONE;
    acc_main = '0;
    acc_oct  = '0;
    acc_dec  = '0;
    flags    = '0;
  endfunction

  // One multiply-add on a magnitude, clamped at the limit for the current sign
  function automatic logic [63:0] sat_mac(logic [63:0] mag, int unsigned b, int unsigned d,
                                          output logic ovf);
    logic [63:0] lim;
    lim = {1'b1, 63'd0} - (neg_sign ? 64'd0 : 64'd1);
    ovf = 1'b0;
    if (b == 0) return mag;
    if (mag > (lim - d) / b) begin
      ovf = 1'b1;
      return lim;
    end
    return mag * b + d;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    int unsigned d;
    logic ovf;
    d = char_digit(c);
    if (radix == BASE_NONE) begin
      // octal/decimal still open: run both until one of them stops
      if (flags.oct_ok) begin
        if (d < BASE_OCT) begin
          acc_oct = sat_mac(acc_oct, BASE_OCT, d, ovf);
          flags.oct_ovf |= ovf;
        end else begin
          flags.oct_ok = 1'b0;
        end
      end
      if (!flags.dec_stop) begin
        if (d < BASE_DEC) begin
          acc_dec = sat_mac(acc_dec, BASE_DEC, d, ovf);
          flags.dec_ovf |= ovf;
        end else begin
          flags.dec_stop = 1'b1;
        end
      end
    end else if (!flags.main_stop) begin
      if (d < radix) begin
        acc_main = sat_mac(acc_main, radix, d, ovf);
        flags.main_ovf |= ovf;
      end else begin
        flags.main_stop = 1'b1;
      end
    end
  endfunction

  function automatic void start_digits(logic [7:0] c);
    int unsigned d;
    d = char_digit(c);
    if (d >= radix) begin
      ph = PH_NAN;
    end else begin
      acc_main = 64'(d);
      ph = PH_DIGITS;
    end
  endfunction

  // A leading zero already counts as a digit of value zero
  function automatic void after_zero(logic [7:0] c);
    ph = PH_DIGITS;
    if (radix == BASE_NONE) flags.oct_ok = 1'b1;
    take_digit(c);
  endfunction

  function automatic void parse_char(logic [7:0] c, logic bg, logic [7:0] bv);
    case (ph)
      PH_START: begin
        if (bg && (bv < BASE_MIN || bv > BASE_MAX)) begin
          ph = PH_NAN;
        end else begin
          if (bg) radix = bv[5:0];
          if (c == CH_ZERO) begin
            ph = PH_ZERO;
          end else if (c == CH_MINUS) begin
            neg_sign = 1'b1;
            ph = PH_SIGN;
          end else if (c == CH_PLUS) begin
            ph = PH_SIGN;
          end else begin
            if (radix == BASE_NONE) radix = BASE_DEC;
            if (is_blank(c)) ph = PH_WS;
            else start_digits(c);
          end
        end
      end
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          if (radix == BASE_NONE) radix = BASE_HEX;
          ph = PH_HEX;
        end else begin
          after_zero(c);
        end
      end
      PH_SIGN: begin
        if (c == CH_ZERO) begin
          ph = PH_SIGN_ZERO;
        end else begin
          if (radix == BASE_NONE) radix = BASE_DEC;
          start_digits(c);
        end
      end
      PH_SIGN_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) ph = PH_NAN;
        else after_zero(c);
      end
      PH_WS: begin
        if (c == CH_MINUS) begin
          neg_sign = 1'b1;
          ph = PH_WANT;
        end else if (c == CH_PLUS) begin
          ph = PH_WANT;
        end else if (!is_blank(c)) begin
          start_digits(c);
        end
      end
      PH_HEX: begin
        if (c == CH_MINUS) begin
          neg_sign = 1'b1;
          ph = PH_WANT;
        end else if (c == CH_PLUS) begin
          ph = PH_WANT;
        end else begin
          start_digits(c);
        end
      end
      PH_WANT:   start_digits(c);
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  // Advance the predictor by one transfer; returns 1 when the string ends here
  function automatic logic predict_item(logic [7:0] c, logic noc, logic last, logic bg,
                                        logic [7:0] bv, output result_t r);
    logic [63:0] mag;
    logic        ovf;
    logic        nan;
    mag = '0;
    ovf = 1'b0;
    nan = 1'b0;
    r = '0;
    if (!noc) parse_char(c, bg, bv);
    if (!noc && !last) return 1'b0;
    if (ph == PH_DIGITS) begin
      if (radix == BASE_NONE) begin
        if (flags.oct_ok) begin
          mag = acc_oct;
          ovf = flags.oct_ovf;
        end else begin
          mag = acc_dec;
          ovf = flags.dec_ovf;
        end
      end else begin
        mag = acc_main;
        ovf = flags.main_ovf;
      end
    end else if (ph != PH_ZERO && ph != PH_SIGN_ZERO) begin
      nan = 1'b1;
    end
    r.is_nan   = nan;
    r.overflow = ovf;
    r.value    = nan ? 64'd0 : (neg_sign ? 64'd0 - mag : mag);
    clear_parse();
    return 1'b1;
  endfunction

  // Check results first, then predict from input transfers of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (pending_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing pending", n_checked));
        end else begin
          want = pending_q.pop_front();
          if (m_axis_tdata !== want.value)
            flag_error($sformatf("result %0d value %0d, predicted %0d", n_checked,
                                 $signed(m_axis_tdata), $signed(want.value)));
          if (m_axis_tuser[0] !== want.is_nan)
            flag_error($sformatf("result %0d is_nan %b, predicted %b", n_checked,
                                 m_axis_tuser[0], want.is_nan));
          if (m_axis_tuser[1] !== want.overflow)
            flag_error($sformatf("result %0d overflow %b, predicted %b", n_checked,
                                 m_axis_tuser[1], want.overflow));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_item(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast, s_axis_tdata[8],
                         s_axis_tdata[16:9], got)) begin
          pending_q.push_back(got);
          n_strings++;
          if (got.is_nan) n_nan++;
          if (got.overflow) n_sat++;
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when asked for
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(logic [7:0] c, logic noc, logic last, logic bg, logic [7:0] bv);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, bv, bg, c};
    s_axis_tuser  <= noc;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
  endtask

  // Send one string; the radix rides on the first byte, later bytes carry random radix bits.
  // With end_by_flag the string is closed by an extra transfer with no byte.
  task automatic send_bytes(byte_q_t q, logic bg, logic [7:0] bv, logic end_by_flag);
    if (q.size() == 0) begin
      send_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), bg, bv);
      return;
    end
    foreach (q[i]) begin
      send_item(q[i], 1'b0, (i == q.size() - 1) && !end_by_flag,
                (i == 0) ? bg : 1'($urandom_range(1)),
                (i == 0) ? bv : 8'($urandom_range(255)));
    end
    if (end_by_flag)
      send_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)),
                1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic send_text(string txt, logic bg = 1'b0, logic [7:0] bv = 8'd0,
                           logic end_by_flag = 1'b0);
    byte_q_t q;
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    send_bytes(q, bg, bv, end_by_flag);
  endtask

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(1) ? CH_A_UP : CH_A_LO) + d - 10);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Mostly well-formed numbers behind a random prefix, some noise and broken tails
  task automatic send_random_string();
    byte_q_t     q;
    int unsigned form, eff, ndig;
    logic        bg;
    logic [7:0]  bv;
    bg = ($urandom_range(3) == 0);
    bv = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(2, 36));
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(255)));
    end else begin
      form = $urandom_range(7);
      case (form)
        1: begin
          repeat ($urandom_range(1, 3)) q.push_back(pick_blank());
          if ($urandom_range(1)) q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        end
        2: q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        3: q.push_back(CH_ZERO);
        4: begin
          q.push_back(CH_ZERO);
          q.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
          if ($urandom_range(2) == 0) q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        end
        5: begin
          q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
          q.push_back(CH_ZERO);
        end
        6: begin
          q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
          q.push_back(CH_ZERO);
          q.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
        end
        7: q.push_back(8'($urandom_range(255)));
        default: ;
      endcase
      eff = BASE_DEC;
      if (form == 4) eff = BASE_HEX;
      else if (form == 3 || form == 5) eff = ($urandom_range(2) == 0) ? BASE_DEC : BASE_OCT;
      if (bg && bv >= BASE_MIN && bv <= BASE_MAX) eff = bv;
      ndig = ($urandom_range(9) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 8);
      repeat (ndig) q.push_back(digit_char($urandom_range(eff - 1)));
      if ($urandom_range(4) == 0) begin
        q.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(3)) q.push_back(digit_char($urandom_range(eff - 1)));
      end
    end
    send_bytes(q, bg, bv, $urandom_range(9) == 0);
  endtask

  task automatic test_empty_and_zero();
    send_text("");
    send_text("0");
    send_text("-0");
    send_text("+0");
  endtask

  task automatic test_prefixes();
    send_text("0x1F");
    send_text("0X-ff");
    send_text("0x+a7");
    send_text("-0x5");
    send_text("017");
    send_text("-0179");
    send_text("+08");
    send_text("0x");
    send_text("0x-");
  endtask

  task automatic test_whitespace_and_signs();
    send_text("  \t\n\015-42");
    send_text("   ");
    send_text("-");
    send_text("+");
    send_text("12ab");
  endtask

  task automatic test_explicit_radix();
    send_text("1012", 1'b1, 8'd2);
    send_text("zZ", 1'b1, 8'd36);
    send_text("0x12", 1'b1, 8'd10);
    send_text("5", 1'b1, 8'd1);
    send_text("5", 1'b1, 8'd37);
    send_text("5", 1'b1, 8'd255);
    send_text("19", 1'b0, 8'd3);
  endtask

  task automatic test_saturation();
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("-9223372036854775808");
    send_text("-9223372036854775809");
    send_text("0x7fffffffffffffff0");
    send_text("0777777777777777777777777");
    send_text("0799999999999999999999");
  endtask

  // High bytes and strings closed by a transfer that carries no byte
  task automatic test_odd_endings();
    send_text("\200");
    send_text("1\2779");
    send_text("\377");
    send_text("12", 1'b0, 8'd0, 1'b1);
    send_text("-", 1'b0, 8'd0, 1'b1);
  endtask

  // Stall the result side long enough that the input backs up
  task automatic test_back_pressure();
    byte_q_t one;
    hold_off_req = 1'b1;
    repeat (40) begin
      one = {digit_char($urandom_range(9))};
      send_bytes(one, 1'b0, 8'd0, 1'b0);
    end
  endtask

  task automatic test_no_idle_burst();
    int unsigned stop_at;
    stop_at = n_items + 200;
    idle_on = 1'b0;
    while (n_items < stop_at) send_random_string();
    idle_on = 1'b1;
  endtask

  task automatic test_random_strings();
    int unsigned stop_at;
    stop_at = n_items + 650;
    while (n_items < stop_at) send_random_string();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    idle_on       = 1'b1;
    hold_off_req  = 1'b0;
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_zero();
    test_prefixes();
    test_whitespace_and_signs();
    test_explicit_radix();
    test_saturation();
    test_odd_endings();
    test_back_pressure();
    test_no_idle_burst();
    test_random_strings();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_q.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", pending_q.size()));

    $display("Run covered %0d strings over %0d byte transfers (%0d NaN, %0d saturated).",
             n_strings, n_items, n_nan, n_sat);
    $display("%0d results checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
